### rtl/ads_pkg.sv
package ads_pkg;

  // Field widths of the tick and result items
  localparam int HOUR_W     = 5;
  localparam int MIN_W      = 6;
  localparam int EPOCH_W    = 32;
  localparam int MS_W       = 32;
  localparam int VOL_W      = 8;
  localparam int PHASE_W    = 3;
  localparam int LAST_MIN_W = 7;

  // Configuration port
  localparam int IVL_W      = 6;
  localparam int QUIET_W    = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE      = 3'd0,
    REG_INTERVAL    = 3'd1,
    REG_QUIET_VALID = 3'd2,
    REG_QUIET_START = 3'd3,
    REG_QUIET_STOP  = 3'd4,
    REG_ALLOW_MUSIC = 3'd5
  } ads_reg_e;

  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE = 3'd0,
    PH_DOWN = 3'd1,
    PH_PREP = 3'd2,
    PH_PLAY = 3'd3,
    PH_UP   = 3'd4
  } ads_phase_e;

  // Timing and level constants
  localparam int DEFAULT_IVL    = 60;
  localparam int RETRIGGER_S    = 30;
  localparam int PREP_MS        = 150;
  localparam int PLAY_MIN_MS    = 1500;
  localparam int PLAY_MAX_MS    = 8000;
  localparam int FADE_UP_MAX_MS = 12000;
  localparam int FADE_FLOOR     = 4;
  localparam int LAST_MIN_NONE  = 127;
  localparam int IVL_RESET      = 60;

  // Minute remainder unit: two remainder bits per cycle
  localparam int DIV_BITS_PER_STEP = 2;
  localparam int DIV_STEPS         = MIN_W / DIV_BITS_PER_STEP;
  localparam int DIV_CNT_W         = $clog2(DIV_STEPS);

  typedef struct packed {
    logic               mode_ok;
    logic               clock_valid;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [EPOCH_W-1:0] epoch_seconds;
    logic [MS_W-1:0]    now_ms;
    logic               player_running;
    logic [VOL_W-1:0]   player_volume;
  } ads_tick_t;

  typedef struct packed {
    logic               volume_write;
    logic [VOL_W-1:0]   volume_level;
    logic               speak_now;
    logic [HOUR_W-1:0]  speak_hour;
    logic [MIN_W-1:0]   speak_minute;
    logic               output_locked;
    logic               amp_enabled;
    logic               announce_active;
    logic               restart_stream;
    logic [PHASE_W-1:0] phase;
  } ads_res_t;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } ads_cmd_t;

  typedef struct packed {
    logic div_last;
  } ads_sts_t;

endpackage

### rtl/ads_tick_if.sv
interface ads_tick_if;
  import ads_pkg::*;

  logic               valid;
  logic               ready;
  logic               mode_ok;
  logic               clock_valid;
  logic [HOUR_W-1:0]  hour;
  logic [MIN_W-1:0]   minute;
  logic [EPOCH_W-1:0] epoch_seconds;
  logic [MS_W-1:0]    now_ms;
  logic               player_running;
  logic [VOL_W-1:0]   player_volume;

  modport source (
    output valid, mode_ok, clock_valid, hour, minute, epoch_seconds, now_ms,
           player_running, player_volume,
    input  ready
  );

  modport sink (
    input  valid, mode_ok, clock_valid, hour, minute, epoch_seconds, now_ms,
           player_running, player_volume,
    output ready
  );
endinterface

### rtl/ads_res_if.sv
interface ads_res_if;
  import ads_pkg::*;

  logic               valid;
  logic               ready;
  logic               volume_write;
  logic [VOL_W-1:0]   volume_level;
  logic               speak_now;
  logic [HOUR_W-1:0]  speak_hour;
  logic [MIN_W-1:0]   speak_minute;
  logic               output_locked;
  logic               amp_enabled;
  logic               announce_active;
  logic               restart_stream;
  logic [PHASE_W-1:0] phase;

  modport source (
    output valid, volume_write, volume_level, speak_now, speak_hour, speak_minute,
           output_locked, amp_enabled, announce_active, restart_stream, phase,
    input  ready
  );

  modport sink (
    input  valid, volume_write, volume_level, speak_now, speak_hour, speak_minute,
           output_locked, amp_enabled, announce_active, restart_stream, phase,
    output ready
  );
endinterface

### rtl/ads_ctrl.sv
module ads_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              tick_valid_i,
  output logic              tick_ready_o,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  input  ads_pkg::ads_sts_t sts_i,
  output ads_pkg::ads_cmd_t cmd_o
);
  import ads_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EXEC
  } state_e;

  state_e state_q, state_d;
  logic   out_vld_q, out_vld_d;
  logic   out_free;
  logic   accept;

  // Output slot is free when empty or being drained this cycle
  assign out_free     = !out_vld_q || res_ready_i;
  assign tick_ready_o = (state_q == ST_IDLE) || (state_q == ST_EXEC && out_free);
  assign accept       = tick_valid_i && tick_ready_o;
  assign res_valid_o  = out_vld_q;

  // Issue commands and pick the next state
  always_comb begin
    cmd_o.load   = accept;
    cmd_o.step   = (state_q == ST_DIV);
    cmd_o.commit = (state_q == ST_EXEC) && out_free;
    state_d      = state_q;
    out_vld_d    = out_vld_q;
    if (res_ready_i) begin
      out_vld_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts_i.div_last) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          state_d   = accept ? ST_DIV : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold state and the result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  a_div_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && sts_i.div_last) |=> state_q == ST_EXEC)
    else $error("remainder unit finished but no exec cycle followed");

  a_accept_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tick_valid_i && tick_ready_o) |=> state_q == ST_DIV)
    else $error("accepted item did not start the remainder unit");

  a_exec_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC && out_vld_q && !res_ready_i) |=> state_q == ST_EXEC)
    else $error("exec left while the result slot was still full");

  a_rise_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == ST_EXEC))
    else $error("result appeared without an exec cycle");

endmodule

### rtl/ads_dp.sv
module ads_dp #(
  parameter int VOLUME_BITS = 8,
  parameter int TIMER_BITS  = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ads_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ads_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  ads_pkg::ads_tick_t           tick_i,
  input  ads_pkg::ads_cmd_t            cmd_i,
  output ads_pkg::ads_sts_t            sts_o,
  output ads_pkg::ads_res_t            res_o
);
  import ads_pkg::*;

  // Configuration registers
  logic               en_q, qv_q, aom_q;
  logic [IVL_W-1:0]   ivl_q;
  logic [QUIET_W-1:0] qstart_q, qstop_q;

  // Captured tick
  logic                   in_mode_q, in_cv_q, in_run_q;
  logic [HOUR_W-1:0]      in_hour_q;
  logic [MIN_W-1:0]       in_min_q;
  logic [EPOCH_W-1:0]     in_epoch_q;
  logic [TIMER_BITS-1:0]  in_now_q;
  logic [VOLUME_BITS-1:0] in_pvol_q;

  // Minute remainder unit
  logic [MIN_W-1:0]     dvd_q, rem_q, rem_d;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [IVL_W-1:0]     ivl_eff;
  logic [MIN_W:0]       part;

  // Sequencer state
  ads_phase_e             phase_q, phase_d;
  logic [LAST_MIN_W-1:0]  last_min_q, last_min_d;
  logic [EPOCH_W-1:0]     last_epoch_q, last_epoch_d;
  logic                   music_q, music_d;
  logic [VOLUME_BITS-1:0] saved_q, saved_d;
  logic [VOLUME_BITS-1:0] lvl_q, lvl_d;
  logic [VOLUME_BITS-1:0] goal_q, goal_d;
  logic [TIMER_BITS-1:0]  pstart_q, pstart_d;
  logic                   begun_q, begun_d;
  logic                   restarted_q, restarted_d;
  logic                   lock_q, lock_d;
  logic                   amp_q, amp_d;
  logic                   active_q, active_d;

  // Per-tick decode
  logic [QUIET_W-1:0]     cur_min;
  logic                   quiet;
  logic                   go;
  logic                   duck;
  logic                   trigger;
  logic [TIMER_BITS-1:0]  elapsed;
  logic [EPOCH_W-1:0]     epoch_gap;
  logic [VOLUME_BITS-1:0] quarter;
  logic                   vw, spk, rst;
  logic [VOLUME_BITS-1:0] vl;
  ads_res_t               res_q, res_d;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q     <= 1'b0;
      ivl_q    <= IVL_W'(IVL_RESET);
      qv_q     <= 1'b0;
      qstart_q <= '0;
      qstop_q  <= '0;
      aom_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_ENABLE:      en_q     <= cfg_data_i[0];
        REG_INTERVAL:    ivl_q    <= cfg_data_i[IVL_W-1:0];
        REG_QUIET_VALID: qv_q     <= cfg_data_i[0];
        REG_QUIET_START: qstart_q <= cfg_data_i[QUIET_W-1:0];
        REG_QUIET_STOP:  qstop_q  <= cfg_data_i[QUIET_W-1:0];
        REG_ALLOW_MUSIC: aom_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Capture the tick
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_mode_q  <= tick_i.mode_ok;
      in_cv_q    <= tick_i.clock_valid;
      in_hour_q  <= tick_i.hour;
      in_min_q   <= tick_i.minute;
      in_epoch_q <= tick_i.epoch_seconds;
      in_now_q   <= TIMER_BITS'(tick_i.now_ms);
      in_run_q   <= tick_i.player_running;
      in_pvol_q  <= VOLUME_BITS'(tick_i.player_volume);
    end
  end

  // Restoring remainder of minute by interval, two bits per cycle
  assign ivl_eff = (ivl_q == '0) ? IVL_W'(DEFAULT_IVL) : ivl_q;

  always_comb begin
    part = {1'b0, rem_q};
    for (int b = 0; b < DIV_BITS_PER_STEP; b++) begin
      part = {part[MIN_W-1:0], dvd_q[MIN_W-1-b]};
      if (part >= {1'b0, ivl_eff}) begin
        part = part - {1'b0, ivl_eff};
      end
    end
    rem_d = part[MIN_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.load) begin
      cnt_q <= '0;
    end else if (cmd_i.step) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dvd_q <= tick_i.minute;
      rem_q <= '0;
    end else if (cmd_i.step) begin
      dvd_q <= dvd_q << DIV_BITS_PER_STEP;
      rem_q <= rem_d;
    end
  end

  assign sts_o.div_last = (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));

  // Minute of day: hour * 60 as hour * 64 - hour * 4
  assign cur_min = (QUIET_W'(in_hour_q) << 6) - (QUIET_W'(in_hour_q) << 2)
                 + QUIET_W'(in_min_q);

  // Quiet window, possibly wrapping past midnight
  always_comb begin
    if (!qv_q || qstart_q == qstop_q) begin
      quiet = 1'b0;
    end else if (qstart_q < qstop_q) begin
      quiet = (cur_min >= qstart_q) && (cur_min < qstop_q);
    end else begin
      quiet = (cur_min >= qstart_q) || (cur_min < qstop_q);
    end
  end

  assign go        = en_q && in_mode_q && in_cv_q && !quiet;
  assign duck      = aom_q && music_q;
  assign elapsed   = in_now_q - pstart_q;
  assign epoch_gap = in_epoch_q - last_epoch_q;
  assign trigger   = (rem_q == '0) && ({1'b0, in_min_q} != last_min_q)
                   && (epoch_gap >= EPOCH_W'(RETRIGGER_S));
  assign quarter   = in_pvol_q >> 2;

  // Advance the announcement sequence by one tick
  always_comb begin
    phase_d      = phase_q;
    last_min_d   = last_min_q;
    last_epoch_d = last_epoch_q;
    music_d      = music_q;
    saved_d      = saved_q;
    lvl_d        = lvl_q;
    goal_d       = goal_q;
    pstart_d     = pstart_q;
    begun_d      = begun_q;
    restarted_d  = restarted_q;
    lock_d       = lock_q;
    amp_d        = amp_q;
    active_d     = active_q;
    vw           = 1'b0;
    vl           = '0;
    spk          = 1'b0;
    rst          = 1'b0;
    if (go) begin
      case (phase_q)
        PH_DOWN: begin
          if (lvl_q > goal_q) begin
            lvl_d = lvl_q - 1'b1;
            vw    = 1'b1;
            vl    = lvl_d;
          end else begin
            phase_d  = PH_PREP;
            pstart_d = in_now_q;
          end
        end
        PH_PREP: begin
          if (elapsed >= TIMER_BITS'(PREP_MS)) begin
            active_d = 1'b1;
            lock_d   = 1'b1;
            spk      = 1'b1;
            vw       = 1'b1;
            vl       = saved_q;
            amp_d    = 1'b1;
            phase_d  = PH_PLAY;
            pstart_d = in_now_q;
          end
        end
        PH_PLAY: begin
          if (elapsed >= TIMER_BITS'(PLAY_MIN_MS)
              && (!in_run_q || elapsed > TIMER_BITS'(PLAY_MAX_MS))) begin
            if (duck) begin
              phase_d = PH_UP;
            end else begin
              lock_d   = 1'b0;
              amp_d    = 1'b0;
              active_d = 1'b0;
              phase_d  = PH_IDLE;
            end
            pstart_d = in_now_q;
          end
        end
        PH_UP: begin
          if (!begun_q) begin
            lvl_d   = in_pvol_q;
            goal_d  = saved_q;
            begun_d = 1'b1;
          end
          if (!restarted_q && !in_run_q) begin
            lock_d      = 1'b0;
            rst         = 1'b1;
            restarted_d = 1'b1;
          end
          if (lvl_d < goal_d) begin
            lvl_d = lvl_d + 1'b1;
            vw    = 1'b1;
            vl    = lvl_d;
          end else begin
            vw          = 1'b1;
            vl          = saved_q;
            active_d    = 1'b0;
            begun_d     = 1'b0;
            restarted_d = 1'b0;
            phase_d     = PH_IDLE;
          end
          // Give up on a fade that runs too long
          if (elapsed > TIMER_BITS'(FADE_UP_MAX_MS)) begin
            lock_d      = 1'b0;
            vw          = 1'b1;
            vl          = saved_q;
            active_d    = 1'b0;
            begun_d     = 1'b0;
            restarted_d = 1'b0;
            phase_d     = PH_IDLE;
          end
        end
        default: begin
          phase_d = PH_IDLE;
          if (trigger) begin
            music_d      = in_run_q;
            saved_d      = in_pvol_q;
            last_epoch_d = in_epoch_q;
            last_min_d   = {1'b0, in_min_q};
            // Skip over running music unless ducking is allowed
            if (!(in_run_q && !aom_q)) begin
              if (in_run_q) begin
                lvl_d   = in_pvol_q;
                goal_d  = (quarter < VOLUME_BITS'(FADE_FLOOR)) ?
                          VOLUME_BITS'(FADE_FLOOR) : quarter;
                phase_d = PH_DOWN;
              end else begin
                phase_d = PH_PREP;
              end
              pstart_d = in_now_q;
            end
          end
        end
      endcase
    end
  end

  // Assemble the result item
  always_comb begin
    res_d.volume_write    = vw;
    res_d.volume_level    = vw ? VOL_W'(vl) : '0;
    res_d.speak_now       = spk;
    res_d.speak_hour      = spk ? in_hour_q : '0;
    res_d.speak_minute    = spk ? in_min_q : '0;
    res_d.output_locked   = lock_d;
    res_d.amp_enabled     = amp_d;
    res_d.announce_active = active_d;
    res_d.restart_stream  = rst;
    res_d.phase           = PHASE_W'(phase_d);
  end

  // Commit sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      last_min_q   <= LAST_MIN_W'(LAST_MIN_NONE);
      last_epoch_q <= '0;
      music_q      <= 1'b0;
      saved_q      <= '0;
      lvl_q        <= '0;
      goal_q       <= '0;
      pstart_q     <= '0;
      begun_q      <= 1'b0;
      restarted_q  <= 1'b0;
      lock_q       <= 1'b0;
      amp_q        <= 1'b0;
      active_q     <= 1'b0;
    end else if (cmd_i.commit) begin
      phase_q      <= phase_d;
      last_min_q   <= last_min_d;
      last_epoch_q <= last_epoch_d;
      music_q      <= music_d;
      saved_q      <= saved_d;
      lvl_q        <= lvl_d;
      goal_q       <= goal_d;
      pstart_q     <= pstart_d;
      begun_q      <= begun_d;
      restarted_q  <= restarted_d;
      lock_q       <= lock_d;
      amp_q        <= amp_d;
      active_q     <= active_d;
    end
  end

  // Hold the result item until taken
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

### rtl/announce_ducking_sequencer_top.sv
// Channel   Dir  Handshake      Payload
// tick_i    in   valid/ready    mode_ok clock_valid hour minute epoch_seconds now_ms
//                               player_running player_volume
// res_o     out  valid/ready    volume_write volume_level speak_now speak_hour
//                               speak_minute output_locked amp_enabled
//                               announce_active restart_stream phase
// cfg       in   cfg_we_i       cfg_index_i, cfg_data_i (no read-back)
//
// Each tick first runs the minute remainder unit (two bits per cycle) after
// the accept edge, then an update cycle that commits state and loads the
// result register. The next tick is taken in that update cycle, so a new tick
// is accepted while the last one is being committed.
// A stalled result holds the update cycle, and with it the next tick, until
// res_o is taken. Reset is asynchronous, active low, and idles the sequencer.
module announce_ducking_sequencer_top #(
  parameter int VOLUME_BITS = 8,
  parameter int TIMER_BITS  = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ads_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ads_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  ads_tick_if.sink                        tick_i,
  ads_res_if.source                       res_o
);
  import ads_pkg::*;

  ads_tick_t tick;
  ads_res_t  res;
  ads_cmd_t  cmd;
  ads_sts_t  sts;

  // Pack the tick fields
  always_comb begin
    tick.mode_ok        = tick_i.mode_ok;
    tick.clock_valid    = tick_i.clock_valid;
    tick.hour           = tick_i.hour;
    tick.minute         = tick_i.minute;
    tick.epoch_seconds  = tick_i.epoch_seconds;
    tick.now_ms         = tick_i.now_ms;
    tick.player_running = tick_i.player_running;
    tick.player_volume  = tick_i.player_volume;
  end

  ads_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tick_valid_i (tick_i.valid),
    .tick_ready_o (tick_i.ready),
    .res_valid_o  (res_o.valid),
    .res_ready_i  (res_o.ready),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  ads_dp #(
    .VOLUME_BITS (VOLUME_BITS),
    .TIMER_BITS  (TIMER_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .tick_i      (tick),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_o       (res)
  );

  // Unpack the result item
  assign res_o.volume_write    = res.volume_write;
  assign res_o.volume_level    = res.volume_level;
  assign res_o.speak_now       = res.speak_now;
  assign res_o.speak_hour      = res.speak_hour;
  assign res_o.speak_minute    = res.speak_minute;
  assign res_o.output_locked   = res.output_locked;
  assign res_o.amp_enabled     = res.amp_enabled;
  assign res_o.announce_active = res.announce_active;
  assign res_o.restart_stream  = res.restart_stream;
  assign res_o.phase           = res.phase;

endmodule
